@@ rtl/rlsd_pkg.sv @@
// Shared types and constants for the run-length strip decoder.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package rlsd_pkg;

  // Strip geometry
  localparam int unsigned ROW_WIDTH  = 240;
  localparam int unsigned STRIP_ROWS = 8;

  // Field widths
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned INDEX_W = 11;
  localparam int unsigned SKIP_W  = 16;
  localparam int unsigned POS_W   = 17;
  localparam int unsigned CFG_W   = 2;

  localparam logic [INDEX_W-1:0] STRIP_SIZE = INDEX_W'(ROW_WIDTH * STRIP_ROWS);

  // Configuration register indexes
  localparam logic [CFG_W-1:0] CFG_SKIP_PIXELS = 2'd0;
  localparam logic [CFG_W-1:0] CFG_DEST_START  = 2'd1;
  localparam logic [CFG_W-1:0] CFG_DRAW_COUNT  = 2'd2;
  localparam logic [CFG_W-1:0] CFG_COLOUR_ON   = 2'd3;

  typedef enum logic [1:0] {
    PH_WAIT,
    PH_DATA,
    PH_LEN,
    PH_COL
  } phase_t;

endpackage

`default_nettype wire

@@ rtl/rlsd_if.sv @@
// Handshake channels of the strip decoder: coded words in, pixel runs out,
// and the configuration write channel. Depends on rlsd_pkg.
`default_nettype none

interface rlsd_word_if import rlsd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] data_word;
  logic              first_word;

  modport source (output valid, data_word, first_word, input ready);
  modport sink   (input valid, data_word, first_word, output ready);
endinterface

interface rlsd_pix_if import rlsd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] dest_index;
  logic [WORD_W-1:0]  pixel_colour;
  logic [INDEX_W-1:0] run_count;
  logic               strip_full;

  modport source (output valid, dest_index, pixel_colour, run_count, strip_full,
                  input ready);
  modport sink   (input valid, dest_index, pixel_colour, run_count, strip_full,
                  output ready);
endinterface

interface rlsd_cfg_if import rlsd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CFG_W-1:0]  index;
  logic [WORD_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/rlsd_colour.sv @@
// Colour stage: byte-swapped RGB565 pass-through or greyscale conversion.
// Depends on rlsd_pkg.
`default_nettype none

module rlsd_colour import rlsd_pkg::*; (
  input  wire logic              colour_on,
  input  wire logic [WORD_W-1:0] colour,
  output logic      [WORD_W-1:0] colour_o
);

  logic [4:0] red;
  logic [5:0] green;
  logic [4:0] blue;
  logic [7:0] luma_sum;
  logic [5:0] luma;

  // Byte-swapped layout: green is split across both bytes.
  assign red      = colour[7:3];
  assign green    = {colour[2:0], colour[15:13]};
  assign blue     = colour[12:8];
  assign luma_sum = {2'b00, red, 1'b0} + {2'b00, green} + {2'b00, blue, 1'b0};
  assign luma     = luma_sum[7:2];

  assign colour_o = colour_on ? colour
                              : {luma[2:0], luma[5:1], luma[5:1], luma[5:3]};

endmodule

`default_nettype wire

@@ rtl/rle_logo_strip_decoder.sv @@
// Top level of the run-length strip decoder: input register, parser state,
// clip logic and result register. Depends on rlsd_pkg, rlsd_if, rlsd_colour.
`default_nettype none

// Decodes an escape-marker run-length RGB565 stream into strip buffer writes.
// One coded word is taken per clock while the result register is not stalled;
// a word that yields a result passes from the input register through the parser
// update into the result register. While a result waits, one more word is taken
// into the input register and then the input stalls until the result is taken.
// Throughput is one word per cycle while no result waits; the parser update
// (marker compare, skip add and window clip) sits between the input register and
// the result register. Configuration writes are always ready and must be
// made while the block is idle; no clearing pass follows reset.
module rle_logo_strip_decoder import rlsd_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  rlsd_word_if.sink   coded,
  rlsd_pix_if.source  pixels,
  rlsd_cfg_if.sink    cfg
);

  // Configuration registers
  logic [SKIP_W-1:0]  skip_pixels;
  logic [INDEX_W-1:0] dest_start;
  logic [INDEX_W-1:0] draw_count;
  logic               colour_on;

  // Input register
  logic              s1_valid;
  logic [WORD_W-1:0] s1_word;
  logic              s1_first;

  // Parser state
  phase_t             phase, phase_next;
  logic [WORD_W-1:0]  marker, marker_next;
  logic [POS_W-1:0]   pend, pend_next;
  logic [POS_W-1:0]   src, src_next;
  logic [INDEX_W-1:0] dest, dest_next;
  logic               done, done_next;

  logic               advance;
  logic               proc;
  logic [INDEX_W-1:0] limit;
  logic               src_lt_skip;
  logic [POS_W-1:0]   run_end;
  logic               emit_req;
  logic [POS_W-1:0]   emit_len;
  logic [INDEX_W-1:0] room;
  logic [INDEX_W-1:0] clip_len;
  logic [INDEX_W:0]   dest_sum;
  logic               res_hit;
  logic               res_full;
  logic [WORD_W-1:0]  res_colour;

  assign cfg.ready   = 1'b1;
  assign advance     = !pixels.valid || pixels.ready;
  assign proc        = s1_valid && advance;
  assign coded.ready = !s1_valid || advance;

  assign limit       = (draw_count < STRIP_SIZE) ? draw_count : STRIP_SIZE;
  assign src_lt_skip = src < {1'b0, skip_pixels};
  assign run_end     = src + pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_pixels <= '0;
      dest_start  <= '0;
      draw_count  <= STRIP_SIZE;
      colour_on   <= 1'b1;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_SKIP_PIXELS: skip_pixels <= cfg.data;
        CFG_DEST_START:  dest_start  <= cfg.data[INDEX_W-1:0];
        CFG_DRAW_COUNT:  draw_count  <= cfg.data[INDEX_W-1:0];
        CFG_COLOUR_ON:   colour_on   <= cfg.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (coded.ready) begin
      s1_valid <= coded.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (coded.ready && coded.valid) begin
      s1_word  <= coded.data_word;
      s1_first <= coded.first_word;
    end
  end

  // Next phase
  always_comb begin
    phase_next = phase;
    if (s1_first) begin
      phase_next = PH_DATA;
    end else begin
      case (phase)
        PH_WAIT: phase_next = PH_WAIT;
        PH_DATA: if (s1_word == marker) phase_next = PH_LEN;
        PH_LEN:  phase_next = PH_COL;
        PH_COL:  phase_next = PH_DATA;
        default: phase_next = PH_WAIT;
      endcase
    end
  end

  // Datapath and result
  always_comb begin
    marker_next = marker;
    pend_next   = pend;
    src_next    = src;
    dest_next   = dest;
    done_next   = done;
    emit_req    = 1'b0;
    emit_len    = POS_W'(1);
    res_hit     = 1'b0;
    res_full    = 1'b0;
    room        = limit - dest;
    clip_len    = '0;
    dest_sum    = '0;

    if (s1_first) begin
      marker_next = s1_word;
      pend_next   = '0;
      src_next    = '0;
      dest_next   = dest_start;
      done_next   = dest_start >= limit;
    end else begin
      case (phase)
        PH_DATA: begin
          if (s1_word != marker) begin
            if (src_lt_skip) begin
              src_next = src + POS_W'(1);
            end else begin
              emit_req = 1'b1;
            end
          end
        end
        PH_LEN: pend_next = {1'b0, s1_word} + POS_W'(1);
        PH_COL: begin
          if (src_lt_skip) begin
            // Only the part of the run past the skip point is kept.
            src_next = run_end;
            if (run_end > {1'b0, skip_pixels}) begin
              emit_req = 1'b1;
              emit_len = run_end - {1'b0, skip_pixels};
            end
          end else begin
            emit_req = pend != '0;
            emit_len = pend;
          end
        end
        default: ;
      endcase
    end

    if (emit_req) begin
      if (done || dest >= limit) begin
        done_next = 1'b1;
      end else begin
        clip_len  = (emit_len > {6'b0, room}) ? room : emit_len[INDEX_W-1:0];
        dest_sum  = {1'b0, dest} + {1'b0, clip_len};
        res_hit   = 1'b1;
        dest_next = dest_sum[INDEX_W-1:0];
        if (dest_sum >= {1'b0, limit}) begin
          done_next = 1'b1;
          res_full  = 1'b1;
        end
      end
    end
  end

  rlsd_colour u_colour (
    .colour_on (colour_on),
    .colour    (s1_word),
    .colour_o  (res_colour)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_WAIT;
      marker <= '0;
      pend   <= '0;
      src    <= '0;
      dest   <= '0;
      done   <= 1'b0;
    end else if (proc) begin
      phase  <= phase_next;
      marker <= marker_next;
      pend   <= pend_next;
      src    <= src_next;
      dest   <= dest_next;
      done   <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixels.valid <= 1'b0;
    end else if (advance) begin
      pixels.valid <= proc && res_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && res_hit) begin
      pixels.dest_index   <= dest;
      pixels.pixel_colour <= res_colour;
      pixels.run_count    <= clip_len;
      pixels.strip_full   <= res_full;
    end
  end

endmodule

`default_nettype wire

@@ rtl/rlsd_checker.sv @@
// Port-level checks on the strip decoder's result channel, bound to the top.
// Depends on rlsd_pkg and rle_logo_strip_decoder.
`default_nettype none

module rlsd_checker import rlsd_pkg::*; (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [INDEX_W-1:0] dest_index,
  input wire logic [WORD_W-1:0]  pixel_colour,
  input wire logic [INDEX_W-1:0] run_count,
  input wire logic               strip_full
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(dest_index) && $stable(pixel_colour) &&
                                $stable(run_count) && $stable(strip_full))
    else $error("result word changed while stalled");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> run_count != '0)
    else $error("empty run emitted");

  a_in_strip: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, dest_index} + {1'b0, run_count}) <= {1'b0, STRIP_SIZE})
    else $error("run extends past strip buffer");

endmodule

bind rle_logo_strip_decoder rlsd_checker u_rlsd_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (pixels.valid),
  .out_ready    (pixels.ready),
  .dest_index   (pixels.dest_index),
  .pixel_colour (pixels.pixel_colour),
  .run_count    (pixels.run_count),
  .strip_full   (pixels.strip_full)
);

`default_nettype wire
